// File: src/cbin_pkg.sv
// Shared types and constants for the collision row binning block.
// No dependencies; every other file imports this package.
package cbin_pkg;

  localparam int ROWS      = 16;
  localparam int COLS      = 32;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int FILL_W    = $clog2(COLS + 1);
  localparam int IDX_W     = 8;
  localparam int RAD_W     = 12;           // radius as a 12-bit unsigned integer (Q12.0) after Q4 widening
  localparam int OFF_W     = 18;           // signed edge offsets
  localparam int MUL_W     = OFF_W - 1;    // positive offset magnitude
  localparam int SCALE_W   = 24;
  localparam int PROD_W    = MUL_W + SCALE_W;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS_IS_Q4 = 2'd0,
    REG_HALF_WIDTH   = 2'd1,
    REG_HALF_HEIGHT  = 2'd2,
    REG_ROW_SCALE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              op;
    logic [7:0]        inst_id;
    logic              enabled;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]        radius_q;
  } in_item_t;

  typedef struct packed {
    logic [3:0] grid_row;
    logic [4:0] slot;
    logic [7:0] placed_index;
    logic       overflow;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic                radius_is_q4;
    logic [14:0]         half_width;
    logic [14:0]         half_height;
    logic [SCALE_W-1:0]  row_scale;
  } cfg_t;

  // One queued job for the back end: a frame clear or a row range to fill.
  typedef struct packed {
    logic             is_clear;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] row_first;
    logic [ROW_W-1:0] row_last;
  } job_t;

endpackage

// File: src/cbin_front.sv
// Front end: accepts items, drops skipped ones, maps circle edges to rows.
// Depends on cbin_pkg.
module cbin_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cbin_pkg::in_item_t in_item,
  input  cbin_pkg::cfg_t    cfg,
  output logic              push,
  output cbin_pkg::job_t    push_job,
  input  logic              q_full
);
  import cbin_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_MUL_T = 4'b0010,
    F_MUL_B = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  localparam logic [MUL_W-1:0] GMAX = MUL_W'(ROWS - 1);
  localparam logic [ROW_W-1:0] RMAX = ROW_W'(ROWS - 1);

  fstate_t                   state_r, state_nxt;
  logic signed [OFF_W-1:0]   off_t_r, off_b_r;
  logic [IDX_W-1:0]          idx_r;
  logic                      is_clear_r;
  logic [PROD_W-1:0]         prod_r;
  logic [ROW_W-1:0]          g_top_r;

  logic [RAD_W-1:0]          r12;
  logic signed [OFF_W-1:0]   py_s, px_s, r_s, hh_s, hw_s;
  logic signed [OFF_W-1:0]   off_t, off_b, x_lo, x_hi, b_hi;
  logic                      skip;
  logic signed [OFF_W-1:0]   mul_off;
  logic [ROW_W-1:0]          g_bot;
  logic                      accept;

  // Grid coordinate from a registered product and the offset sign.
  function automatic logic [ROW_W-1:0] clamp_g(input logic signed [OFF_W-1:0] off,
                                               input logic [PROD_W-1:0] prod);
    logic [MUL_W-1:0] g;
    g = prod[PROD_W-1:SCALE_W];
    if (off <= 0) begin
      clamp_g = '0;
    end else if (g > GMAX) begin
      clamp_g = RMAX;
    end else begin
      clamp_g = ROW_W'(g);
    end
  endfunction

  assign accept = start && (state_r == F_IDLE);
  assign busy   = (state_r != F_IDLE);

  always_comb begin
    r12  = cfg.radius_is_q4 ? {in_item.radius_q, 4'h0} : {4'h0, in_item.radius_q};
    py_s = OFF_W'($signed(in_item.pos_y));
    px_s = OFF_W'($signed(in_item.pos_x));
    r_s  = signed'(OFF_W'(r12));
    hh_s = signed'(OFF_W'(cfg.half_height));
    hw_s = signed'(OFF_W'(cfg.half_width));
    off_t = py_s + r_s + hh_s;
    off_b = py_s - r_s + hh_s;
    b_hi  = py_s - r_s - hh_s;
    x_lo  = px_s + r_s + hw_s;
    x_hi  = px_s - r_s - hw_s;
    skip  = (off_t < 0) || (b_hi > 0) || (x_lo < 0) || (x_hi > 0);
  end

  assign mul_off = (state_r == F_MUL_T) ? off_t_r : off_b_r;
  assign g_bot   = clamp_g(off_b_r, prod_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_item.op == OP_CLEAR) begin
            state_nxt = F_PUSH;
          end else if (in_item.enabled && !skip) begin
            state_nxt = F_MUL_T;
          end
        end
      end
      F_MUL_T: state_nxt = F_MUL_B;
      F_MUL_B: state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      off_t_r    <= off_t;
      off_b_r    <= off_b;
      idx_r      <= in_item.inst_id;
      is_clear_r <= (in_item.op == OP_CLEAR);
    end
    if (state_r == F_MUL_T || state_r == F_MUL_B) begin
      prod_r <= PROD_W'(mul_off[MUL_W-1:0]) * PROD_W'(cfg.row_scale);
    end
    if (state_r == F_MUL_B) begin
      g_top_r <= clamp_g(off_t_r, prod_r);
    end
  end

  assign push               = (state_r == F_PUSH) && !q_full;
  assign push_job.is_clear  = is_clear_r;
  assign push_job.idx       = idx_r;
  assign push_job.row_first = RMAX - g_top_r;
  assign push_job.row_last  = RMAX - g_bot;

endmodule

// File: src/cbin_queue.sv
// Two-entry job queue between front and back ends.
// Depends on cbin_pkg.
module cbin_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cbin_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output cbin_pkg::job_t head
);
  import cbin_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

endmodule

// File: src/cbin_back.sv
// Back end: walks each job's row range, keeps per-row fill counts, emits results.
// Depends on cbin_pkg.
module cbin_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                not_empty,
  input  cbin_pkg::job_t      head,
  output logic                pop,
  output logic                out_strobe,
  output cbin_pkg::out_item_t out_item
);
  import cbin_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EMIT = 2'b10
  } bstate_t;

  bstate_t             state_r;
  logic [ROW_W-1:0]    cur_r, end_r;
  logic [IDX_W-1:0]    idx_r;
  logic [FILL_W-1:0]   fill_r [ROWS];
  logic                strobe_r;
  out_item_t           item_r;

  logic [FILL_W-1:0]   fill;
  logic                full_row;
  logic                at_end;

  assign pop      = not_empty && (state_r == B_IDLE);
  assign fill     = fill_r[cur_r];
  assign full_row = (fill >= FILL_W'(COLS));
  assign at_end   = (cur_r == end_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      strobe_r <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (pop) begin
            if (head.is_clear) begin
              for (int i = 0; i < ROWS; i++) begin
                fill_r[i] <= '0;
              end
            end else begin
              state_r <= B_EMIT;
            end
          end
        end
        B_EMIT: begin
          strobe_r <= 1'b1;
          if (!full_row) begin
            fill_r[cur_r] <= fill + 1'b1;
          end
          if (at_end) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head.row_first;
      end_r <= head.row_last;
      idx_r <= head.idx;
    end else if (state_r == B_EMIT) begin
      cur_r <= cur_r + 1'b1;
    end
    if (state_r == B_EMIT) begin
      item_r.grid_row     <= 4'(cur_r);
      item_r.slot         <= full_row ? 5'd0 : 5'(fill);
      item_r.placed_index <= full_row ? 8'd0 : idx_r;
      item_r.overflow     <= full_row;
      item_r.last         <= at_end;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

// File: src/collision_row_binning.sv
// Top level of the collision row binning block: configuration registers
// and the front end, job queue and back end. Depends on cbin_pkg and all cbin_ modules.
//
// Usage: drive start with an item on in_item while busy is low; the item
// transfers on that edge. An enabled place item inside the area holds the
// front end through the transfer, two passes of the shared edge-to-row
// multiplier and the queue push, so busy stays high from the transfer until
// the push, longer while the queue is full. A clear item raises busy until
// its queue push; disabled or off-area items transfer without raising busy and cause nothing.
// A clear item travels through the queue, so it takes effect after every
// placement accepted before it. The back end loads a job from the queue,
// then emits one result per covered row per cycle, rows in ascending order,
// with last set on the final one; with an idle back end the first result
// is registered after the job load. Results appear on out_item for exactly one
// cycle, marked by out_strobe; the receiver cannot stall them and must take
// every one. The two-entry queue lets the front end take new items while
// the back end is still emitting. Write the configuration registers only
// while the block is idle; cfg_ready is always high.
module collision_row_binning (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  cbin_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output cbin_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbin_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbin_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import cbin_pkg::*;

  cfg_t cfg_r;
  logic push, q_full, pop, not_empty;
  job_t push_job, head;

  assign cfg_ready = 1'b1;

  // Hold configuration; each register takes the low bits of the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius_is_q4 <= 1'b0;
      cfg_r.half_width   <= 15'd16384;
      cfg_r.half_height  <= 15'd16384;
      cfg_r.row_scale    <= 24'd2048;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_RADIUS_IS_Q4: cfg_r.radius_is_q4 <= cfg_data[0];
        REG_HALF_WIDTH:   cfg_r.half_width   <= cfg_data[14:0];
        REG_HALF_HEIGHT:  cfg_r.half_height  <= cfg_data[14:0];
        REG_ROW_SCALE:    cfg_r.row_scale    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify items and turn circle edges into a row range.
  cbin_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // Decouple the front end from the row walk.
  cbin_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // Walk rows, advance fill counts, emit placements or overflow flags.
  cbin_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .not_empty  (not_empty),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for collision_row_binning: row-fill scoreboard class plus drivers.
// Depends on cbin_pkg and the collision_row_binning RTL.

module testbench;
  import cbin_pkg::*;

  localparam int MAX_PLACEMENTS = 16;
  localparam int TAIL_CYCLES    = 24;

  // Predicts the placements of each transferred item from its own copy of the
  // row counts and configuration, and checks results against them in order.
  class row_bin_scoreboard;
    bit          radius_is_q4;
    logic [14:0] half_width;
    logic [14:0] half_height;
    logic [23:0] row_scale;
    logic [5:0]  row_fill [ROWS];
    out_item_t   placements_due [$];
    int          mismatches;

    function new();
      radius_is_q4 = 1'b0;
      half_width   = 15'd16384;
      half_height  = 15'd16384;
      row_scale    = 24'd2048;
      foreach (row_fill[i]) row_fill[i] = '0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [23:0] data);
      case (idx)
        REG_RADIUS_IS_Q4: radius_is_q4 = data[0];
        REG_HALF_WIDTH:   half_width   = data[14:0];
        REG_HALF_HEIGHT:  half_height  = data[14:0];
        REG_ROW_SCALE:    row_scale    = data;
        default: ;
      endcase
    endfunction

    // Grid coordinate of a horizontal edge, counted from the bottom of the area.
    function int edge_to_grid(int edge_v);
      longint off;
      longint prod;
      off = longint'(edge_v) + longint'(half_height);
      if (off <= 0) return 0;
      prod = (off * longint'(row_scale)) >>> 24;
      if (prod > ROWS - 1) return ROWS - 1;
      return int'(prod);
    endfunction

    function void note_input(in_item_t it);
      int        px, py, rad, hw, hh, g_top, g_bot, g, row, n;
      out_item_t p;
      if (it.op == OP_CLEAR) begin
        foreach (row_fill[i]) row_fill[i] = '0;
        return;
      end
      if (!it.enabled) return;
      px  = $signed(it.pos_x);
      py  = $signed(it.pos_y);
      rad = int'(it.radius_q);
      if (radius_is_q4) rad = rad * 16;
      hw = int'(half_width);
      hh = int'(half_height);
      // Drop circles lying wholly outside the play area.
      if (py + rad < -hh || py - rad > hh || px + rad < -hw || px - rad > hw) return;
      g_top = edge_to_grid(py + rad);
      g_bot = edge_to_grid(py - rad);
      n = 0;
      for (g = g_top; g >= g_bot && n < MAX_PLACEMENTS; g--) begin
        row = ROWS - 1 - g;
        p.grid_row = row[3:0];
        if (row_fill[row] >= COLS) begin
          p.slot         = '0;
          p.placed_index = '0;
          p.overflow     = 1'b1;
        end else begin
          p.slot         = row_fill[row][4:0];
          p.placed_index = it.inst_id;
          p.overflow     = 1'b0;
          row_fill[row]  = row_fill[row] + 6'd1;
        end
        p.last = (g == g_bot) || (n == MAX_PLACEMENTS - 1);
        placements_due.push_back(p);
        n++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      bit        bad;
      if (placements_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result row %0d slot %0d idx %0d ovf %b last %b",
                   $realtime, got.grid_row, got.slot, got.placed_index,
                   got.overflow, got.last);
        return;
      end
      want = placements_due.pop_front();
      bad = (got.grid_row !== want.grid_row) || (got.slot !== want.slot) ||
            (got.placed_index !== want.placed_index) ||
            (got.overflow !== want.overflow) || (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: got row %0d slot %0d idx %0d ovf %b last %b, want %0d %0d %0d %b %b",
                   $realtime, got.grid_row, got.slot, got.placed_index, got.overflow,
                   got.last, want.grid_row, want.slot, want.placed_index,
                   want.overflow, want.last);
      end
    endfunction

    function int pending();
      return placements_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  row_bin_scoreboard sb = new();
  int burst_left = 0;

  collision_row_binning dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict on every input transfer; the block samples start and busy on this edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_input(in_item);
  end

  // Results last one cycle and cannot be stalled: check each strobe as it comes.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Mostly short gaps, a few long ones, and occasional stretches with none at all.
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(logic op, int idx, logic en, int x, int y, int rq);
    in_item_t it;
    it.op       = op;
    it.inst_id  = idx[7:0];
    it.enabled  = en;
    it.pos_x    = x[15:0];
    it.pos_y    = y[15:0];
    it.radius_q = rq[7:0];
    return it;
  endfunction

  // Mostly circles near the play area, so they get past the skip test;
  // the rest use arbitrary positions.
  function automatic in_item_t random_item(int clear_pct);
    in_item_t it;
    int       rad, hw, hh, x, y;
    it.op       = ($urandom_range(0, 99) < clear_pct) ? OP_CLEAR : OP_PLACE;
    it.inst_id  = 8'($urandom());
    it.enabled  = ($urandom_range(0, 9) != 0);
    it.radius_q = 8'($urandom());
    rad = int'(it.radius_q);
    if (sb.radius_is_q4) rad = rad * 16;
    hw = int'(sb.half_width);
    hh = int'(sb.half_height);
    if ($urandom_range(0, 4) == 0) begin
      it.pos_x = 16'($urandom());
      it.pos_y = 16'($urandom());
    end else begin
      x = int'($urandom_range(0, 2 * (hw + rad) + 2)) - hw - rad - 1;
      y = int'($urandom_range(0, 2 * (hh + rad) + 2)) - hh - rad - 1;
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      it.pos_x = x[15:0];
      it.pos_y = y[15:0];
    end
    return it;
  endfunction

  // Present one item and hold it until it transfers; start stays high
  // into the next item unless a gap lowers it.
  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait for every predicted placement to come out.
  task automatic hold_for_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Bring the block to idle: all results in, then a tail for items that
  // cause nothing but may still be in flight.
  task automatic settle_block();
    hold_for_results();
    while (busy) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_cfg(bit q4, int hw, int hh, int scale);
    settle_block();
    write_reg(REG_RADIUS_IS_Q4, {23'd0, q4});
    write_reg(REG_HALF_WIDTH, hw[23:0]);
    write_reg(REG_HALF_HEIGHT, hh[23:0]);
    write_reg(REG_ROW_SCALE, scale[23:0]);
  endtask

  // Random setting: row scale usually sized so the area spans roughly
  // the full grid, sometimes any 24-bit value.
  task automatic apply_random_cfg();
    int     hh;
    longint scale;
    hh = $urandom_range(0, 32767);
    if ($urandom_range(0, 9) < 7) begin
      scale = (longint'(1) << 28) / (2 * hh + 1);
      scale = scale * $urandom_range(50, 150) / 100;
      if (scale > 24'hFFFFFF) scale = 24'hFFFFFF;
    end else begin
      scale = $urandom() & 32'h00FF_FFFF;
    end
    apply_cfg(1'($urandom_range(0, 1)), $urandom_range(0, 32767), hh, int'(scale));
  endtask

  task automatic run_random(int count, int clear_pct);
    repeat (count) begin
      send_item(random_item(clear_pct));
      // Now and then drain completely before the next transfer.
      if ($urandom_range(0, 49) == 0) hold_for_results();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings first, no register written yet.
    run_random(50, 5);

    // Directed: 16 rows over a 16384-unit half height.
    apply_cfg(1'b0, 16384, 16384, 8192);
    send_item(make_item(OP_CLEAR, 0, 1'b0, 0, 0, 0));
    send_item(make_item(OP_PLACE, 0, 1'b0, 0, 0, 255));       // disabled
    send_item(make_item(OP_PLACE, 255, 1'b1, 0, 0, 0));       // zero radius, one row
    send_item(make_item(OP_PLACE, 1, 1'b1, 0, 0, 255));
    send_item(make_item(OP_PLACE, 2, 1'b1, 0, 32767, 255));   // above the area
    send_item(make_item(OP_PLACE, 3, 1'b1, 0, -32768, 255));  // below the area
    send_item(make_item(OP_PLACE, 4, 1'b1, 32767, 0, 255));   // right of the area
    send_item(make_item(OP_PLACE, 5, 1'b1, -32768, 0, 255));  // left of the area
    send_item(make_item(OP_PLACE, 6, 1'b1, 0, -16384, 0));    // top edge on the bottom border
    send_item(make_item(OP_PLACE, 7, 1'b1, 0, -16385, 0));
    send_item(make_item(OP_PLACE, 8, 1'b1, 0, 16384, 0));     // clamped to the top row
    send_item(make_item(OP_PLACE, 9, 1'b1, 0, 16385, 0));
    send_item(make_item(OP_PLACE, 10, 1'b1, 16384, 0, 0));
    send_item(make_item(OP_PLACE, 11, 1'b1, -16385, 0, 0));
    send_item(make_item(OP_PLACE, 12, 1'b1, -16384, 100, 128));
    apply_cfg(1'b1, 16384, 16384, 8192);
    send_item(make_item(OP_PLACE, 13, 1'b1, 0, 0, 255));      // Q4 radius spans rows 6 to 9
    send_item(make_item(OP_PLACE, 14, 1'b1, 0, -20464, 255)); // touches the bottom border
    send_item(make_item(OP_PLACE, 15, 1'b1, 20464, 0, 255));  // touches the right border
    send_item(make_item(OP_CLEAR, 255, 1'b1, -1, -1, 255));
    send_item(make_item(OP_PLACE, 16, 1'b1, 0, 0, 255));

    // Widest area, Q4 radius.
    apply_cfg(1'b1, 32767, 32767, 4096);
    run_random(80, 4);

    // Zero-size area with the largest scale: clamped rows and full spans.
    apply_cfg(1'b0, 0, 0, 16777215);
    send_item(make_item(OP_PLACE, 170, 1'b1, 0, 0, 255));
    run_random(60, 6);

    // Zero scale packs everything into the bottom row, so rows fill and overflow.
    apply_cfg(1'b0, 20000, 20000, 0);
    run_random(70, 1);

    repeat (3) begin
      apply_random_cfg();
      run_random(80, 2 + $urandom_range(0, 6));
    end

    settle_block();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
src/cbin_pkg.sv
src/cbin_front.sv
src/cbin_queue.sv
src/cbin_back.sv
src/collision_row_binning.sv
test/testbench.sv
